FILE: hdl/assert_macros.svh
// Assertion macros for the checker file of the queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define CQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/cqir_pkg.sv
// Package of the circular queue: default sizes, operation and status codes.
`default_nettype none

package cqir_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/cqir_ifs.sv
// Valid/ready channel interfaces for the queue's operation and result beats.
`default_nettype none

interface cqir_in_if
  import cqir_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int POS_WIDTH  = 4
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [DATA_WIDTH-1:0] value;
  logic [POS_WIDTH-1:0]  position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

interface cqir_out_if
  import cqir_pkg::*;
#(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int COUNT_WIDTH = 5
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [DATA_WIDTH-1:0]  front;
  logic [COUNT_WIDTH-1:0] count;

  modport source (output valid, status, front, count, input ready);
  modport sink   (input valid, status, front, count, output ready);
endinterface

`default_nettype wire

FILE: hdl/circular_queue_with_indexed_removal.sv
// Circular queue with removal at a position; store in one synchronous memory.
//
// Operation beats arrive on in_chan (kind, value, position); every beat gives
// exactly one result beat on out_chan (status, front, count), in order.
// A beat is taken only while the sequencer is idle, so one operation is in
// work at a time. Push, clear and every refused operation go straight to
// S_DONE, where the result is registered. A pop passes through S_FRONT_RD and
// S_FRONT_CAP before S_DONE, since the new head word is read back from the
// memory. A removal at position p from a queue of n entries first moves each
// entry behind the gap: it is read and written back one slot nearer the head
// in S_SHIFT_RD and S_SHIFT_WR, through the single read and write ports of
// the memory; then the new front word is read back as for a pop.
// The next beat is accepted in the cycle after the result is registered.
// The result register holds its beat while out_chan.ready is low; one further
// operation may be taken and finished meanwhile, and it then waits until the
// register is free. Reset empties the queue (head slot and count to zero) and
// drops any pending result; the memory contents are not cleared, since only
// live entries are ever reported.
`default_nettype none

module circular_queue_with_indexed_removal
  import cqir_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int PW        = (CW > 4) ? CW : 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cqir_in_if.sink   in_chan,
  cqir_out_if.source out_chan
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FRONT_RD,
    S_FRONT_CAP,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [AW-1:0]         head_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         idx_r;
  logic [DATA_WIDTH-1:0] front_r;
  status_t               status_r;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [DATA_WIDTH-1:0] out_front_r;
  logic [CW-1:0]         out_count_r;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  wr_en;

  logic                  accept;
  op_t                   op;
  logic [PW-1:0]         pos_ext;
  logic                  is_full;

  // Physical slot of the entry at a distance from the head; the sum stays
  // below twice the depth, so one compare and subtract wraps it.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW + 1)'(off);
    if (sum >= (AW + 1)'(DEPTH)) begin
      sum = sum - (AW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign op            = op_t'(in_chan.kind);
  // The position is compared at full width, so a small depth never folds it.
  assign pos_ext       = PW'(in_chan.position);
  assign is_full       = (count_r == CW'(DEPTH));

  assign out_chan.valid  = out_valid_r;
  assign out_chan.status = out_status_r;
  assign out_chan.front  = out_front_r;
  assign out_chan.count  = out_count_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_of(head_r, count_r);
    wr_data = in_chan.value;
    rd_addr = head_r;
    if (state_r == S_IDLE) begin
      wr_en = accept && (op == OP_PUSH) && !is_full;
    end else if (state_r == S_SHIFT_WR) begin
      wr_en   = 1'b1;
      wr_addr = slot_of(head_r, idx_r);
      wr_data = rd_data_r;
    end
    if (state_r == S_SHIFT_RD) begin
      rd_addr = slot_of(head_r, idx_r + CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the result register is reloaded below instead.
      if (out_valid_r && out_chan.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (op)
              OP_PUSH: begin
                state_r <= S_DONE;
                if (is_full) begin
                  status_r <= ST_FULL;
                end else begin
                  status_r <= ST_OK;
                  count_r  <= count_r + CW'(1);
                  if (count_r == '0) begin
                    front_r <= in_chan.value;
                  end
                end
              end
              OP_POP: begin
                if (count_r == '0) begin
                  status_r <= ST_EMPTY;
                  state_r  <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  head_r   <= slot_of(head_r, CW'(1));
                  count_r  <= count_r - CW'(1);
                  state_r  <= S_FRONT_RD;
                end
              end
              OP_REMOVE: begin
                if (pos_ext >= PW'(count_r)) begin
                  status_r <= ST_RANGE;
                  state_r  <= S_DONE;
                end else if (pos_ext + PW'(1) < PW'(count_r)) begin
                  status_r <= ST_OK;
                  idx_r    <= CW'(pos_ext);
                  state_r  <= S_SHIFT_RD;
                end else begin
                  status_r <= ST_OK;
                  count_r  <= count_r - CW'(1);
                  state_r  <= S_FRONT_RD;
                end
              end
              OP_CLEAR: begin
                status_r <= ST_OK;
                head_r   <= '0;
                count_r  <= '0;
                state_r  <= S_DONE;
              end
              default: begin
                status_r <= ST_OK;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_SHIFT_RD: begin
          state_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx_r <= idx_r + CW'(1);
          if (idx_r + CW'(2) < count_r) begin
            state_r <= S_SHIFT_RD;
          end else begin
            count_r <= count_r - CW'(1);
            state_r <= S_FRONT_RD;
          end
        end
        S_FRONT_RD: begin
          state_r <= S_FRONT_CAP;
        end
        S_FRONT_CAP: begin
          front_r <= rd_data_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_count_r  <= count_r;
            out_front_r  <= (count_r != '0) ? front_r : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cqir_checker.sv
// Port-level checker for the circular queue, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module cqir_checker
  import cqir_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [1:0]            out_status,
  input wire logic [DATA_WIDTH-1:0] out_front,
  input wire logic [CW-1:0]         out_count
);

  // A stalled result beat keeps its payload.
  `CQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_front) && $stable(out_count) && $stable(out_status), "result beat changed while stalled")

  `CQ_ASSERT_NEVER(a_count_max, clk, rst_n, out_valid && (out_count > CW'(DEPTH)), "count beyond depth")

  `CQ_ASSERT_NEVER(a_empty_front, clk, rst_n, out_valid && (out_count == '0) && (out_front != '0), "front not zero on an empty queue")

  // A refused push means the queue was full, a refused pop that it was empty.
  `CQ_ASSERT_NEVER(a_full_count, clk, rst_n, out_valid && (out_status == ST_FULL) && (out_count != CW'(DEPTH)), "full status below depth")

  `CQ_ASSERT_NEVER(a_empty_count, clk, rst_n, out_valid && (out_status == ST_EMPTY) && (out_count != '0), "empty status with entries held")

endmodule

bind circular_queue_with_indexed_removal cqir_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_cqir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_front  (out_chan.front),
  .out_count  (out_chan.count)
);

`default_nettype wire
